### hw/rtl/chacha20_stream_xor_macros.svh
// Assertion macros shared by the ChaCha20 stream XOR checker.
// Stand-alone header; the including file supplies clock, reset and signals.
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_SAME(label, c_clk, c_rst_n, ante, cons) \
    label: assert property (@(posedge c_clk) disable iff (!c_rst_n) (ante) |-> (cons)) \
        else $error("cc20 checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(label, c_clk, c_rst_n, ante, cons) \
    label: assert property (@(posedge c_clk) disable iff (!c_rst_n) (ante) |=> (cons)) \
        else $error("cc20 checker: next-cycle property failed");

`endif

### hw/rtl/cc20_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 stream XOR.
// No dependencies; every file but the assertion macros header uses this package.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF  = 10;
    localparam int BYTES_PER_ITEM_DEF = 8;
    localparam int MAX_ITEM_BYTES     = 8;
    localparam int DATA_W             = 64;
    localparam int CNT_W              = 4;
    localparam int CFG_IDX_W          = 3;
    localparam int POS_W              = 6;
    localparam int BLOCK_WORDS        = 16;
    localparam int BLOCK_W            = 512;

    // The four constant words ("expand 32-byte k").
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef logic [31:0] word_t;

    // One quarter-round lane: the four words it works on.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Configuration registers as held by the top level.
    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce;
    } cfg_regs_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_NONCE = 3'd4
    } cfg_reg_t;

    // Item sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_GEN,
        S_FIN
    } seq_state_t;

    // Block core states.
    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ADD
    } core_state_t;

    // Rotate left by a constant amount.
    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Mask covering the low n bytes of a data word.
    function automatic logic [DATA_W-1:0] byte_mask(logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_ITEM_BYTES; i++)
        begin
            if (CNT_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

### hw/rtl/cc20_if.sv
// Handshake interfaces for the message input, result output and register write channels.
// Depends on cc20_pkg for field widths.
interface cc20_in_if;
    logic                             valid;
    logic                             ready;
    logic [cc20_pkg::DATA_W-1:0]      data_in;
    logic [cc20_pkg::CNT_W-1:0]       byte_count;
    logic                             start_of_message;

    modport source (output valid, output data_in, output byte_count,
                    output start_of_message, input ready);
    modport sink   (input valid, input data_in, input byte_count,
                    input start_of_message, output ready);
endinterface

interface cc20_out_if;
    logic                             valid;
    logic                             ready;
    logic [cc20_pkg::DATA_W-1:0]      data_out;
    logic [cc20_pkg::CNT_W-1:0]       byte_count_out;

    modport source (output valid, output data_out, output byte_count_out, input ready);
    modport sink   (input valid, input data_out, input byte_count_out, output ready);
endinterface

interface cc20_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cc20_pkg::CFG_IDX_W-1:0]   index;
    logic [63:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/chacha20_stream_xor.sv
// ChaCha20 stream XOR, 64-bit nonce and 64-bit block counter, up to eight bytes per transfer.
// An item moves through the sequencer states S_PROC and S_FIN into the output register; one
// that needs a fresh 64-byte block also waits in S_GEN (40 half-round steps, then the add).
// One item at a time: a new item is taken only once the last result is loaded for output.
// Reset: asynchronous, active low; clears key, nonce, block counter and byte position.
// Depends on cc20_pkg, cc20_if and cc20_core.
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS  = cc20_pkg::DOUBLE_ROUNDS_DEF,
    parameter int BYTES_PER_ITEM = cc20_pkg::BYTES_PER_ITEM_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    cc20_in_if.sink         msg_in,
    cc20_out_if.source      msg_out,
    cc20_cfg_if.sink        cfg
);
    import cc20_pkg::*;

    localparam int LIMIT = (BYTES_PER_ITEM < MAX_ITEM_BYTES) ? BYTES_PER_ITEM : MAX_ITEM_BYTES;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

    seq_state_t             state_reg;
    seq_state_t             state_next;
    cfg_regs_t              cfg_regs_reg;
    logic [63:0]            counter_reg;
    logic [63:0]            counter_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   blk_rdy_reg;
    logic                   blk_rdy_next;
    logic [BLOCK_W-1:0]     ks_reg;
    logic [DATA_W-1:0]      data_reg;
    logic [DATA_W-1:0]      result_reg;
    logic [CNT_W-1:0]       done_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic [CNT_W-1:0]       out_cnt_reg;
    logic                   out_valid_reg;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   cfg_xfer;
    logic [CNT_W-1:0]       count_sat;
    logic [POS_W:0]         avail;
    logic [CNT_W-1:0]       take;
    logic [DATA_W-1:0]      xor_bytes;
    logic [POS_W:0]         pos_sum;
    logic                   consume;
    logic                   core_start;
    logic                   core_done;
    logic [BLOCK_W-1:0]     core_ks;
    logic                   fin_load;

    assign in_xfer  = msg_in.valid & msg_in.ready;
    assign out_xfer = msg_out.valid & msg_out.ready;
    assign cfg_xfer = cfg.valid & cfg.ready;

    // Saturate the byte count to the item limit.
    assign count_sat = (msg_in.byte_count > LIMIT_C) ? LIMIT_C : msg_in.byte_count;

    // Bytes taken this cycle: what remains of the item, capped at what remains of the block.
    assign avail     = (POS_W+1)'(64) - {1'b0, pos_reg};
    assign take      = ({3'b000, rem_reg} < avail) ? rem_reg : avail[CNT_W-1:0];
    assign xor_bytes = (data_reg ^ ks_reg[DATA_W-1:0]) & byte_mask(take);
    assign pos_sum   = {1'b0, pos_reg} + {3'b000, take};

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs_reg),
        .counter   (counter_reg),
        .start     (core_start),
        .done      (core_done),
        .keystream (core_ks)
    );

    // Next state of the item sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (rem_reg == '0 || (consume && take == rem_reg))
                begin
                    state_next = S_FIN;
                end
                else if (!blk_rdy_reg)
                begin
                    state_next = S_GEN;
                end
            end
            S_GEN:
            begin
                if (core_done)
                begin
                    state_next = S_PROC;
                end
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs. Register writes are taken only between items, so a block
    // under generation always sees one key and nonce.
    always_comb
    begin
        msg_in.ready = (state_reg == S_IDLE);
        cfg.ready    = (state_reg == S_IDLE);
        consume      = (state_reg == S_PROC) && (rem_reg != '0) && blk_rdy_reg;
        core_start   = (state_reg == S_PROC) && (rem_reg != '0) && !blk_rdy_reg;
        fin_load     = (state_reg == S_FIN) && (!out_valid_reg || msg_out.ready);
    end

    // Block counter, byte position and keystream-ready flag.
    always_comb
    begin
        counter_next = counter_reg;
        pos_next     = pos_reg;
        blk_rdy_next = blk_rdy_reg;
        if (in_xfer && msg_in.start_of_message)
        begin
            counter_next = '0;
            pos_next     = '0;
            blk_rdy_next = 1'b0;
        end
        else if (consume)
        begin
            pos_next = pos_sum[POS_W-1:0];
            if (pos_sum[POS_W])
            begin
                blk_rdy_next = 1'b0;
                counter_next = counter_reg + 64'd1;
            end
        end
        else if (core_done)
        begin
            blk_rdy_next = 1'b1;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_regs_reg  <= '0;
            counter_reg   <= '0;
            pos_reg       <= '0;
            blk_rdy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            blk_rdy_reg <= blk_rdy_next;
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_xfer)
            begin
                case (cfg.index)
                    REG_KEY0:  cfg_regs_reg.key0  <= cfg.data;
                    REG_KEY1:  cfg_regs_reg.key1  <= cfg.data;
                    REG_KEY2:  cfg_regs_reg.key2  <= cfg.data;
                    REG_KEY3:  cfg_regs_reg.key3  <= cfg.data;
                    REG_NONCE: cfg_regs_reg.nonce <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item and keystream datapath; consumed bytes shift out at the low end.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_reg   <= msg_in.data_in;
            rem_reg    <= count_sat;
            done_reg   <= '0;
            result_reg <= '0;
        end
        else if (consume)
        begin
            data_reg   <= data_reg >> {take, 3'b000};
            result_reg <= result_reg | (xor_bytes << {done_reg, 3'b000});
            rem_reg    <= rem_reg - take;
            done_reg   <= done_reg + take;
        end
        if (consume)
        begin
            ks_reg <= ks_reg >> {take, 3'b000};
        end
        else if (core_done)
        begin
            ks_reg <= core_ks;
        end
        if (fin_load)
        begin
            out_data_reg <= result_reg;
            out_cnt_reg  <= done_reg;
        end
    end

    assign msg_out.valid          = out_valid_reg;
    assign msg_out.data_out       = out_data_reg;
    assign msg_out.byte_count_out = out_cnt_reg;

endmodule

### hw/rtl/cc20_half_round.sv
// Shared arithmetic unit: half of a quarter round on four independent lanes.
// Depends on cc20_pkg for quad_t and rotl.
module cc20_half_round
(
    input  logic                    second,
    input  cc20_pkg::quad_t [3:0]   lane_in,
    output cc20_pkg::quad_t [3:0]   lane_out
);
    import cc20_pkg::*;

    // Each lane does a += b, d ^= a, rotate, c += d, b ^= c, rotate.
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        word_t a_sum;
        word_t d_mix;
        word_t d_rot;
        word_t c_sum;
        word_t b_mix;
        word_t b_rot;

        assign a_sum = lane_in[g].a + lane_in[g].b;
        assign d_mix = lane_in[g].d ^ a_sum;
        assign d_rot = second ? rotl(d_mix, 8) : rotl(d_mix, 16);
        assign c_sum = lane_in[g].c + d_rot;
        assign b_mix = lane_in[g].b ^ c_sum;
        assign b_rot = second ? rotl(b_mix, 7) : rotl(b_mix, 12);

        assign lane_out[g] = '{a: a_sum, b: b_rot, c: c_sum, d: d_rot};
    end

endmodule

### hw/rtl/cc20_core.sv
// Keystream block generator: sixteen state words stepped through the shared
// half-round unit under a small sequencer, then the feed-forward add.
// Depends on cc20_pkg and cc20_half_round.
module cc20_core #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cc20_pkg::cfg_regs_t             cfg_regs,
    input  logic [63:0]                     counter,
    input  logic                            start,
    output logic                            done,
    output logic [cc20_pkg::BLOCK_W-1:0]    keystream
);
    import cc20_pkg::*;

    localparam int STEPS  = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    core_state_t          state_reg;
    core_state_t          state_next;
    logic [STEP_W-1:0]    step_reg;
    word_t                w_reg [BLOCK_WORDS];
    word_t                w_upd [BLOCK_WORDS];
    word_t                init_w [BLOCK_WORDS];
    logic                 diag;
    logic                 second;
    logic [3:0]           idx_b [4];
    logic [3:0]           idx_c [4];
    logic [3:0]           idx_d [4];
    quad_t [3:0]          lane_in;
    quad_t [3:0]          lane_out;

    // Input state: constants, key, block counter, nonce.
    always_comb
    begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        init_w[4]  = cfg_regs.key0[31:0];
        init_w[5]  = cfg_regs.key0[63:32];
        init_w[6]  = cfg_regs.key1[31:0];
        init_w[7]  = cfg_regs.key1[63:32];
        init_w[8]  = cfg_regs.key2[31:0];
        init_w[9]  = cfg_regs.key2[63:32];
        init_w[10] = cfg_regs.key3[31:0];
        init_w[11] = cfg_regs.key3[63:32];
        init_w[12] = counter[31:0];
        init_w[13] = counter[63:32];
        init_w[14] = cfg_regs.nonce[31:0];
        init_w[15] = cfg_regs.nonce[63:32];
    end

    // Step order within a double round: column first half, column second half,
    // diagonal first half, diagonal second half.
    assign diag   = step_reg[1];
    assign second = step_reg[0];

    // Gather the four lanes for the current step.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            idx_b[i] = diag ? 4'(4 + ((i + 1) & 3)) : 4'(4 + i);
            idx_c[i] = diag ? 4'(8 + ((i + 2) & 3)) : 4'(8 + i);
            idx_d[i] = diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
            lane_in[i] = '{a: w_reg[i], b: w_reg[idx_b[i]],
                           c: w_reg[idx_c[i]], d: w_reg[idx_d[i]]};
        end
    end

    cc20_half_round u_half_round
    (
        .second   (second),
        .lane_in  (lane_in),
        .lane_out (lane_out)
    );

    // Scatter the lane results back into the state words.
    always_comb
    begin
        w_upd = w_reg;
        for (int i = 0; i < 4; i++)
        begin
            w_upd[i]        = lane_out[i].a;
            w_upd[idx_b[i]] = lane_out[i].b;
            w_upd[idx_c[i]] = lane_out[i].c;
            w_upd[idx_d[i]] = lane_out[i].d;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Outputs: the block is ready in the feed-forward cycle.
    always_comb
    begin
        done = (state_reg == C_ADD);
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            keystream[32*i +: 32] = w_reg[i] + init_w[i];
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == C_IDLE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == C_RUN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Working state words.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            w_reg <= init_w;
        end
        else if (state_reg == C_RUN)
        begin
            w_reg <= w_upd;
        end
    end

endmodule

### hw/rtl/cc20_checker.sv
// Port-level checks for the ChaCha20 stream XOR, bound to the top level.
// Depends on cc20_pkg and chacha20_stream_xor_macros.svh.
`include "chacha20_stream_xor_macros.svh"

module cc20_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cc20_pkg::DATA_W-1:0]  out_data,
    input logic [cc20_pkg::CNT_W-1:0]   out_cnt
);
    import cc20_pkg::*;

    // A stalled result holds its valid and payload.
    `CC20_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_cnt))

    // The block works on one item at a time: no transfer straight after another.
    `CC20_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // A result never reports more bytes than an item carries.
    `CC20_ASSERT_SAME(a_cnt_range, clk, rst_n, out_valid, out_cnt <= CNT_W'(MAX_ITEM_BYTES))

    // A result with no valid bytes carries all-zero data.
    `CC20_ASSERT_SAME(a_zero_data, clk, rst_n, out_valid && out_cnt == '0, out_data == '0)

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg_in.valid),
    .in_ready  (msg_in.ready),
    .out_valid (msg_out.valid),
    .out_ready (msg_out.ready),
    .out_data  (msg_out.data_out),
    .out_cnt   (msg_out.byte_count_out)
);

### tb/sv/chacha20_stream_xor_checker.sv
`timescale 1ns / 1ps
// Result checker for the ChaCha20 stream XOR: watches the register write, message and result
// channels, predicts each result and compares it field by field. Depends on cc20_pkg and cc20_if.
module cc20_stream_checker #(
    parameter int DOUBLE_ROUNDS  = cc20_pkg::DOUBLE_ROUNDS_DEF,
    parameter int BYTES_PER_ITEM = cc20_pkg::BYTES_PER_ITEM_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cc20_in_if   msg_in,
    cc20_out_if  msg_out,
    cc20_cfg_if  cfg,
    output int   mismatches,
    output int   awaiting
);
    import cc20_pkg::*;

    localparam int ITEM_LIMIT = (BYTES_PER_ITEM < MAX_ITEM_BYTES) ? BYTES_PER_ITEM
                                                                   : MAX_ITEM_BYTES;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } cipher_result_t;

    // Shadow copy of the key and nonce registers.
    logic [63:0]      key_q [4];
    logic [63:0]      nonce_q;

    // Keystream state: block counter, current block, byte position within it.
    logic [63:0]      block_ctr;
    word_t            ks_word [BLOCK_WORDS];
    logic [POS_W-1:0] ks_pos;
    logic             ks_valid;

    cipher_result_t   results_due [$];

    function automatic word_t rot_left(word_t v, int n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    // Build the next 64-byte keystream block from the current key, counter and nonce.
    task automatic refill_keystream();
        word_t init [BLOCK_WORDS];
        word_t x [BLOCK_WORDS];
        int    a, b, c, d, j, sh;
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (int k = 0; k < 4; k++)
        begin
            init[4 + 2 * k] = key_q[k][31:0];
            init[5 + 2 * k] = key_q[k][63:32];
        end
        init[12] = block_ctr[31:0];
        init[13] = block_ctr[63:32];
        init[14] = nonce_q[31:0];
        init[15] = nonce_q[63:32];
        x = init;
        // Column quarter rounds first, then the diagonal ones.
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            for (int q = 0; q < 8; q++)
            begin
                j  = q % 4;
                sh = (q < 4) ? 0 : 1;
                a  = j;
                b  = 4 + (j + sh) % 4;
                c  = 8 + (j + 2 * sh) % 4;
                d  = 12 + (j + 3 * sh) % 4;
                x[a] = x[a] + x[b];
                x[d] = rot_left(x[d] ^ x[a], 16);
                x[c] = x[c] + x[d];
                x[b] = rot_left(x[b] ^ x[c], 12);
                x[a] = x[a] + x[b];
                x[d] = rot_left(x[d] ^ x[a], 8);
                x[c] = x[c] + x[d];
                x[b] = rot_left(x[b] ^ x[c], 7);
            end
        end
        for (int k = 0; k < BLOCK_WORDS; k++)
        begin
            ks_word[k] = x[k] + init[k];
        end
        ks_valid = 1'b1;
    endtask

    // XOR one message transfer with the keystream and advance the byte position.
    task automatic cipher_item(input logic [DATA_W-1:0] din, input logic [CNT_W-1:0] n_in,
                               input logic som, output cipher_result_t res);
        logic [CNT_W-1:0] n;
        logic [7:0]       ks_byte;
        if (som)
        begin
            block_ctr = '0;
            ks_pos    = '0;
            ks_valid  = 1'b0;
        end
        n = (n_in > ITEM_LIMIT) ? CNT_W'(ITEM_LIMIT) : n_in;
        res.data  = '0;
        res.count = n;
        for (int i = 0; i < n; i++)
        begin
            if (!ks_valid)
            begin
                refill_keystream();
            end
            ks_byte = ks_word[ks_pos[5:2]][8 * ks_pos[1:0] +: 8];
            res.data[8 * i +: 8] = din[8 * i +: 8] ^ ks_byte;
            ks_pos = ks_pos + 1'b1;
            if (ks_pos == '0)
            begin
                ks_valid  = 1'b0;
                block_ctr = block_ctr + 64'd1;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Results are checked before new expectations are queued in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        cipher_result_t due;
        cipher_result_t fresh;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_q[k] = '0;
            end
            for (int k = 0; k < BLOCK_WORDS; k++)
            begin
                ks_word[k] = '0;
            end
            nonce_q    = '0;
            block_ctr  = '0;
            ks_pos     = '0;
            ks_valid   = 1'b0;
            mismatches = 0;
            results_due.delete();
        end
        else
        begin
            if (msg_out.valid && msg_out.ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_mismatch("result with nothing expected", msg_out.data_out, '0);
                end
                else
                begin
                    due = results_due.pop_front();
                    if (msg_out.data_out !== due.data)
                    begin
                        flag_mismatch("data_out", msg_out.data_out, due.data);
                    end
                    if (msg_out.byte_count_out !== due.count)
                    begin
                        flag_mismatch("byte_count_out", 64'(msg_out.byte_count_out),
                                      64'(due.count));
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KEY0:  key_q[0] = cfg.data;
                    REG_KEY1:  key_q[1] = cfg.data;
                    REG_KEY2:  key_q[2] = cfg.data;
                    REG_KEY3:  key_q[3] = cfg.data;
                    REG_NONCE: nonce_q  = cfg.data;
                    default:   ;
                endcase
            end

            if (msg_in.valid && msg_in.ready)
            begin
                cipher_item(msg_in.data_in, msg_in.byte_count, msg_in.start_of_message, fresh);
                results_due.push_back(fresh);
            end
        end
        awaiting = results_due.size();
    end

endmodule

### tb/sv/tb_chacha20_stream_xor.sv
`timescale 1ns / 1ps
// Testbench top for the ChaCha20 stream XOR: clock, reset, register writes, message stimulus,
// receiver back-pressure and the verdict. Depends on cc20_pkg, cc20_if, the block and the checker.
module tb_chacha20_stream_xor;
    import cc20_pkg::*;

    localparam int NO_TRANSFER_LIMIT = 4000;
    localparam int SETTLE_CYCLES     = 60;
    localparam int HOLD_OFF_CYCLES   = 400;
    localparam int PHASE_COUNT       = 8;
    localparam int PHASE_ITEMS       = 104;

    logic clk   = 1'b0;
    logic rst_n;
    int   in_idle_pct   = 0;
    int   out_stall_pct = 0;
    logic hold_off_req  = 1'b0;
    int   quiet_cycles  = 0;
    int   mismatches;
    int   awaiting;

    cc20_in_if  msg_in ();
    cc20_out_if msg_out ();
    cc20_cfg_if cfg_bus ();

    chacha20_stream_xor i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_in),
        .msg_out (msg_out),
        .cfg     (cfg_bus)
    );

    cc20_stream_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .msg_out    (msg_out),
        .cfg        (cfg_bus),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always #5 clk = ~clk;

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (msg_in.valid && msg_in.ready) || (msg_out.valid && msg_out.ready)
            || (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= NO_TRANSFER_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        msg_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                msg_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                msg_out.ready <= ($urandom_range(99) >= out_stall_pct);
                @(posedge clk);
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    // Offer one message transfer after a random gap and wait until it is taken.
    task automatic send_item(input logic [DATA_W-1:0] d, input logic [CNT_W-1:0] n,
                             input logic som);
        while ($urandom_range(99) < in_idle_pct)
        begin
            msg_in.valid <= 1'b0;
            @(posedge clk);
        end
        msg_in.valid            <= 1'b1;
        msg_in.data_in          <= d;
        msg_in.byte_count       <= n;
        msg_in.start_of_message <= som;
        @(posedge clk);
        while (!msg_in.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain_results();
        msg_in.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_all(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] nonce_v);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE, nonce_v);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random messages: mostly full transfers, some short ones, a little noise.
    task automatic run_phase(input int idle_in, input int stall_out, input int items,
                             input bit pressure);
        int               sent;
        int               msg_len;
        int               pick;
        bit               opening;
        logic             som;
        logic [CNT_W-1:0] n;
        logic [DATA_W-1:0] d;
        in_idle_pct   = idle_in;
        out_stall_pct = stall_out;
        sent          = 0;
        opening       = 1'b1;
        while (sent < items)
        begin
            msg_len = $urandom_range(40, 1);
            for (int k = 0; k < msg_len && sent < items; k++)
            begin
                if (k == 0)
                begin
                    // The first message of a phase may carry on the old keystream.
                    som = opening ? 1'($urandom_range(1)) : 1'b1;
                end
                else
                begin
                    som = ($urandom_range(49) == 0);
                end
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    n = 4'd8;
                end
                else if (pick < 90)
                begin
                    n = CNT_W'($urandom_range(7, 1));
                end
                else if (pick < 95)
                begin
                    n = 4'd0;
                end
                else
                begin
                    n = CNT_W'($urandom_range(15, 9));
                end
                pick = $urandom_range(19);
                d = (pick == 0) ? '0 : (pick == 1) ? '1 : rand_data();
                if (pressure && sent == items / 2)
                begin
                    hold_off_req = 1'b1;
                end
                send_item(d, n, som);
                sent++;
            end
            opening = 1'b0;
        end
        drain_results();
    endtask

    initial
    begin
        int idle_in;
        int stall_out;
        rst_n                   <= 1'b0;
        msg_in.valid            <= 1'b0;
        msg_in.data_in          <= '0;
        msg_in.byte_count       <= '0;
        msg_in.start_of_message <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= REG_KEY0;
        cfg_bus.data            <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: all-zero key, extreme data, short and empty transfers,
        // oversized counts, a block boundary inside a transfer and a bare restart.
        program_all('0, '0, '0, '0, '0);
        send_item('0, 4'd8, 1'b1);
        send_item('1, 4'd8, 1'b0);
        send_item(rand_data(), 4'd3, 1'b0);
        send_item(rand_data(), 4'd0, 1'b0);
        repeat (5) send_item(rand_data(), 4'd8, 1'b0);
        send_item(rand_data(), 4'd15, 1'b0);
        send_item(rand_data(), 4'd9, 1'b0);
        send_item(rand_data(), 4'd1, 1'b0);
        send_item(rand_data(), 4'd0, 1'b1);
        send_item(rand_data(), 4'd8, 1'b0);
        drain_results();

        // Key change in the middle of a block: the current block stays in use,
        // the next one is built with the new key.
        write_reg(REG_KEY2, '1);
        cfg_bus.valid <= 1'b0;
        send_item(rand_data(), 4'd5, 1'b0);
        repeat (7) send_item(rand_data(), 4'd8, 1'b0);
        drain_results();

        // Random phases over several key settings and idling patterns.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case ((p + p / 4) % 4)
                0:       program_all('1, '1, '1, '1, '1);
                1:       program_all(rand_data(), rand_data(), rand_data(), rand_data(),
                                     rand_data());
                2:       program_all('0, '0, '0, '0, '1);
                default: program_all(rand_data(), rand_data(), rand_data(), rand_data(), '0);
            endcase
            idle_in   = (p % 4 == 1) ? 86 : (p % 4 == 3) ? 17 : 0;
            stall_out = (p % 4 == 2) ? 86 : (p % 4 == 3) ? 17 : 0;
            run_phase(idle_in, stall_out, PHASE_ITEMS, p == 0);
        end

        if (mismatches == 0 && awaiting == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
